// ----- rtl/core/efd_pkg.sv -----
// ----------------------------------------------------------------------------
// efd_pkg: shared definitions for the event frame store
// Frame geometry, field widths, operation and register codes, and the
// controller to datapath command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    // Frame geometry
    localparam int SIDE      = 128;
    localparam int PIX_COUNT = SIDE * SIDE;
    localparam int ADDR_W    = $clog2(PIX_COUNT);

    // Field widths
    localparam int COORD_W = 7;
    localparam int COMP_W  = 8;
    localparam int COLOR_W = 3 * COMP_W;
    localparam int FUNC_W  = 2;
    localparam int CIDX_W  = 2;

    // Operation codes carried in tuser
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DECAY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DECAY_STEP = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MID_COLOR  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_ON_COLOR   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_OFF_COLOR  = 2'd3;

    // Reset values
    localparam logic [COMP_W-1:0]  DECAY_STEP_RST = 8'd24;
    localparam logic [COLOR_W-1:0] MID_COLOR_RST  = 24'h808080;
    localparam logic [COLOR_W-1:0] ON_COLOR_RST   = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] OFF_COLOR_RST  = 24'h000000;
    localparam logic [COLOR_W-1:0] CLEAR_COLOR    = 24'h808080;

    // Controller -> datapath commands
    typedef struct packed {
        logic clr_wr;    // write clear color at walk address, advance walk
        logic walk_rd;   // read pixel at walk address for decay, advance walk
        logic ev_wr;     // write event color at item address
        logic px_rd;     // read pixel at item address
        logic out_load;  // load output register from read data
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic walk_last; // walk address is on the last pixel
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/event_frame_with_decay.sv -----
// ----------------------------------------------------------------------------
// event_frame_with_decay: RGB frame store for an event sensor
// Square frame of packed RGB pixels written by events, faded toward a rest
// color by decay ticks, and read back one pixel at a time.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole pixel memory to mid gray, one pixel
// per cycle, and holds s_axis_tready low meanwhile; config writes are taken
// during the sweep. Then: an event transaction is a single memory write, a read
// is a memory read, then a load of the output register, and a decay tick walks
// every pixel through the single memory port pair, reading one pixel while
// writing back the previous one, and holds s_axis_tready low until the last
// pixel is written back. Func code 3 is taken and dropped. A read waits in its
// output load step for as long as the previous result is still held
// unaccepted in the output register.
// Only reads produce an output transaction; coordinates outside the frame
// read as black and are ignored by events.
// ----------------------------------------------------------------------------
`default_nettype none

module event_frame_with_decay
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // config write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [efd_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [efd_pkg::COLOR_W-1:0]   cfg_data,

    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // x[6:0], y[13:7], polarity[14]
    input  wire logic [efd_pkg::FUNC_W-1:0]    s_axis_tuser,  // func[1:0]

    // output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [efd_pkg::COLOR_W-1:0]        m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

    localparam int CW = efd_pkg::COMP_W;

    efd_pkg::cmd_t cmd;
    efd_pkg::sts_t sts;
    logic [efd_pkg::COLOR_W-1:0] out_color;

    // registers are always writable
    assign cfg_ready = 1'b1;

    efd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    efd_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_x        (s_axis_tdata[6:0]),
        .in_y        (s_axis_tdata[13:7]),
        .in_polarity (s_axis_tdata[14]),
        .cmd         (cmd),
        .sts         (sts),
        .out_color   (out_color)
    );

    // stored color is red high; stream carries red in the low byte
    assign m_axis_tdata = {out_color[CW-1:0], out_color[2*CW-1:CW], out_color[3*CW-1:2*CW]};

endmodule

`default_nettype wire

// ----- rtl/core/efd_ctrl.sv -----
// ----------------------------------------------------------------------------
// efd_ctrl: sequencing state machine
// Runs the clear pass after reset, dispatches items, walks decay ticks and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [efd_pkg::FUNC_W-1:0]  in_func,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output efd_pkg::cmd_t                    cmd,
    input  wire efd_pkg::sts_t               sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DECAY = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_func)
                        efd_pkg::FUNC_EVENT: cmd.ev_wr = 1'b1;
                        efd_pkg::FUNC_DECAY: state_next = ST_DECAY;
                        efd_pkg::FUNC_READ:
                        begin
                            cmd.px_rd  = 1'b1;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DECAY:
            begin
                cmd.walk_rd = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last decayed pixel is written back this cycle
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/efd_dp.sv -----
// ----------------------------------------------------------------------------
// efd_dp: frame store datapath
// Config registers, pixel memory, walk counter, decay writeback stage and
// output color register.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_dp
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [efd_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [efd_pkg::COLOR_W-1:0]  cfg_data,
    input  wire logic [efd_pkg::COORD_W-1:0]  in_x,
    input  wire logic [efd_pkg::COORD_W-1:0]  in_y,
    input  wire logic                         in_polarity,
    input  wire efd_pkg::cmd_t                cmd,
    output efd_pkg::sts_t                     sts,
    output logic [efd_pkg::COLOR_W-1:0]       out_color
);

    localparam int AW = efd_pkg::ADDR_W;
    localparam int CW = efd_pkg::COMP_W;
    localparam int KW = efd_pkg::COLOR_W;

    logic [CW-1:0] decay_step_reg;
    logic [KW-1:0] mid_color_reg;
    logic [KW-1:0] on_color_reg;
    logic [KW-1:0] off_color_reg;

    logic [KW-1:0] mem [efd_pkg::PIX_COUNT];
    logic [KW-1:0] rdata_reg;

    logic [AW-1:0] walk_reg, walk_next;
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;
    logic          rd_inside_reg;
    logic [KW-1:0] out_color_reg;

    logic          px_inside;
    logic [AW-1:0] px_addr;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [KW-1:0] mem_wdata;
    logic [KW-1:0] decayed;

    // One 8-bit component one step toward its target, snapping when close
    function automatic logic [CW-1:0] approach(input logic [CW-1:0] cur,
                                               input logic [CW-1:0] tgt,
                                               input logic [CW-1:0] step);
        logic [CW:0] cur_up;
        logic [CW:0] tgt_up;
        logic [CW-1:0] res;
        cur_up = {1'b0, cur} + {1'b0, step};
        tgt_up = {1'b0, tgt} + {1'b0, step};
        if ({1'b0, cur} >= tgt_up)
        begin
            res = cur - step;
        end
        else if (cur_up <= {1'b0, tgt})
        begin
            res = cur_up[CW-1:0];
        end
        else
        begin
            res = tgt;
        end
        return res;
    endfunction

    assign px_inside = (32'(in_x) < efd_pkg::SIDE) && (32'(in_y) < efd_pkg::SIDE);
    assign px_addr   = AW'(32'(in_y) * efd_pkg::SIDE + 32'(in_x));

    assign sts.walk_last = (walk_reg == AW'(efd_pkg::PIX_COUNT - 1));

    always_comb
    begin
        walk_next = walk_reg;
        if (cmd.clr_wr || cmd.walk_rd)
        begin
            walk_next = sts.walk_last ? '0 : walk_reg + AW'(1);
        end
    end

    assign decayed = {approach(rdata_reg[3*CW-1:2*CW], mid_color_reg[3*CW-1:2*CW],
                               decay_step_reg),
                      approach(rdata_reg[2*CW-1:CW], mid_color_reg[2*CW-1:CW],
                               decay_step_reg),
                      approach(rdata_reg[CW-1:0], mid_color_reg[CW-1:0],
                               decay_step_reg)};

    // Write port: clear pass, event write or decay writeback (never together)
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_reg;
        mem_wdata = efd_pkg::CLEAR_COLOR;
        if (cmd.clr_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.ev_wr)
        begin
            mem_we    = px_inside;
            mem_waddr = px_addr;
            mem_wdata = in_polarity ? on_color_reg : off_color_reg;
        end
        else if (wb_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_reg;
            mem_wdata = decayed;
        end
    end

    assign mem_re    = cmd.walk_rd || (cmd.px_rd && px_inside);
    assign mem_raddr = cmd.walk_rd ? walk_reg : px_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wb_addr_reg <= walk_reg;
        if (cmd.px_rd)
        begin
            rd_inside_reg <= px_inside;
        end
        if (cmd.out_load)
        begin
            out_color_reg <= rd_inside_reg ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= '0;
            wb_valid_reg   <= 1'b0;
            decay_step_reg <= efd_pkg::DECAY_STEP_RST;
            mid_color_reg  <= efd_pkg::MID_COLOR_RST;
            on_color_reg   <= efd_pkg::ON_COLOR_RST;
            off_color_reg  <= efd_pkg::OFF_COLOR_RST;
        end
        else
        begin
            walk_reg     <= walk_next;
            wb_valid_reg <= cmd.walk_rd;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    efd_pkg::REG_DECAY_STEP: decay_step_reg <= cfg_data[CW-1:0];
                    efd_pkg::REG_MID_COLOR:  mid_color_reg  <= cfg_data;
                    efd_pkg::REG_ON_COLOR:   on_color_reg   <= cfg_data;
                    efd_pkg::REG_OFF_COLOR:  off_color_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign out_color = out_color_reg;

endmodule

`default_nettype wire
